FILE: src/adr_pkg.sv
package adr_pkg;

    // Default values of the top-level parameters.
    localparam int TEX_SIDE_DEF         = 256;
    localparam int WARMUP_STEPS_DEF     = 11;
    localparam int SINE_TABLE_DEPTH_DEF = 4096;

    // Angle constants in Q30 radians.
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // 2^32 / (2*pi), used to turn a Q32 angle into a turn fraction.
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    // Coordinate mapping: floor((12*v + 25*65536) * side / 65536 / 50).
    localparam logic signed [23:0] COORD_OFFSET = 24'sd1638400;
    localparam logic [16:0]        RECIP_50     = 17'd83887;
    localparam int                 RECIP_SHIFT  = 22;
    localparam int                 W_W          = 17;

    // Wave pipeline: last cycle of the wave phase of one step.
    localparam logic [3:0] WAVE_LAST = 4'd8;

    localparam logic [15:0] CH_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_FADE = 2'd0,
        FUNC_RUN  = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_COEF_A     = 3'd0,
        REG_COEF_B     = 3'd1,
        REG_COEF_C     = 3'd2,
        REG_COEF_D     = 3'd3,
        REG_BRIGHTNESS = 3'd4,
        REG_ITERATIONS = 3'd5,
        REG_FADE       = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        OUT_ZERO  = 2'd0,
        OUT_PIXEL = 2'd1,
        OUT_COUNT = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic      load;
        logic      sweep_clr;
        logic      sweep_inc;
        logic      clr_wr;
        logic      fade_rd;
        logic      wave_issue;
        logic [1:0] wave_slot;
        logic      newpt;
        logic      coord_a;
        logic      coord_b;
        logic      addr_calc;
        logic      pix_rd;
        logic      pix_wr;
        logic      cnt_clr;
        logic      idx_rd;
        logic      out_load;
        out_kind_t out_kind;
    } adr_cmd_t;

    typedef struct packed {
        logic        sweep_last;
        logic        out_free;
        logic [19:0] iters;
    } adr_status_t;

    // Sine of a Q30 angle in [0, 2*pi), rounded to signed Q16.
    function automatic logic signed [17:0] sine_of_angle(longint th_in);
        longint th;
        longint term;
        longint sum;
        longint q;
        logic   neg;
        th  = th_in;
        neg = 1'b0;
        if (th >= PI_Q30) begin
            th  = th - PI_Q30;
            neg = 1'b1;
        end
        if (th > HALF_PI_Q30) th = PI_Q30 - th;
        if (th < 0) th = 0;
        term = th;
        sum  = th;
        term = (term * th) >>> 30;
        term = (term * th) >>> 30;
        term = term / 6;
        sum  = sum - term;
        term = (term * th) >>> 30;
        term = (term * th) >>> 30;
        term = term / 20;
        sum  = sum + term;
        term = (term * th) >>> 30;
        term = (term * th) >>> 30;
        term = term / 42;
        sum  = sum - term;
        term = (term * th) >>> 30;
        term = (term * th) >>> 30;
        term = term / 72;
        sum  = sum + term;
        term = (term * th) >>> 30;
        term = (term * th) >>> 30;
        term = term / 110;
        sum  = sum - term;
        term = (term * th) >>> 30;
        term = (term * th) >>> 30;
        term = term / 156;
        sum  = sum + term;
        if (sum < 0) sum = 0;
        q = (sum + 8192) >>> 14;
        if (q > 65536) q = 65536;
        if (neg) q = -q;
        return 18'(q);
    endfunction

endpackage

FILE: src/adr_sine_rom.sv
module adr_sine_rom #(
    parameter int SINE_TABLE_DEPTH = adr_pkg::SINE_TABLE_DEPTH_DEF,
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH)
) (
    input  logic                clk,
    input  logic [IDX_W-1:0]    addr,
    output logic signed [17:0]  rd_data
);

    logic signed [17:0] rom_mem [SINE_TABLE_DEPTH];
    logic signed [17:0] data_reg;

    // Each entry is the sine of 2*pi*i/depth, evaluated while elaborating.
    for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_ent
        localparam longint TH = (longint'(i) * adr_pkg::TWO_PI_Q30) / SINE_TABLE_DEPTH;
        assign rom_mem[i] = adr_pkg::sine_of_angle(TH);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_mem[addr];
    end

    assign rd_data = data_reg;

endmodule

FILE: src/adr_ctrl.sv
module adr_ctrl #(
    parameter int WARMUP_STEPS = adr_pkg::WARMUP_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           func,
    input  adr_pkg::adr_status_t status,
    output adr_pkg::adr_cmd_t    cmd
);

    typedef enum logic [12:0] {
        ST_CLEAR    = 13'b0000000000001,
        ST_IDLE     = 13'b0000000000010,
        ST_FADE     = 13'b0000000000100,
        ST_FADE_END = 13'b0000000001000,
        ST_WAVE     = 13'b0000000010000,
        ST_NEWPT    = 13'b0000000100000,
        ST_COORD_A  = 13'b0000001000000,
        ST_COORD_B  = 13'b0000010000000,
        ST_ADDR     = 13'b0000100000000,
        ST_PIX_RD   = 13'b0001000000000,
        ST_PIX_WR   = 13'b0010000000000,
        ST_READ     = 13'b0100000000000,
        ST_FINISH   = 13'b1000000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [19:0] it_reg, it_next;
    logic [3:0]  wcnt_reg, wcnt_next;
    logic [1:0]  func_reg, func_next;
    logic        warm;
    logic [20:0] it_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign warm     = (it_reg >= 20'(WARMUP_STEPS));
    assign it_inc   = 21'(it_reg) + 21'd1;

    always_comb
    begin
        state_next = state_reg;
        it_next    = it_reg;
        wcnt_next  = wcnt_reg;
        func_next  = func_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr    = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (status.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load  = 1'b1;
                    func_next = func;
                    case (func)
                        adr_pkg::FUNC_FADE:
                        begin
                            cmd.sweep_clr = 1'b1;
                            state_next    = ST_FADE;
                        end
                        adr_pkg::FUNC_RUN:
                        begin
                            cmd.cnt_clr = 1'b1;
                            it_next     = '0;
                            wcnt_next   = '0;
                            state_next  = (status.iters == '0) ? ST_FINISH : ST_WAVE;
                        end
                        adr_pkg::FUNC_READ: state_next = ST_READ;
                        default:            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_FADE:
            begin
                cmd.fade_rd   = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (status.sweep_last) state_next = ST_FADE_END;
            end
            ST_FADE_END: state_next = ST_FINISH;
            ST_WAVE:
            begin
                cmd.wave_issue = (wcnt_reg < 4'd4);
                cmd.wave_slot  = wcnt_reg[1:0];
                wcnt_next      = wcnt_reg + 4'd1;
                if (wcnt_reg == adr_pkg::WAVE_LAST) state_next = ST_NEWPT;
            end
            ST_NEWPT:
            begin
                cmd.newpt  = 1'b1;
                state_next = ST_COORD_A;
            end
            ST_COORD_A:
            begin
                cmd.coord_a = 1'b1;
                state_next  = ST_COORD_B;
            end
            ST_COORD_B:
            begin
                cmd.coord_b = 1'b1;
                state_next  = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.addr_calc = 1'b1;
                state_next    = ST_PIX_RD;
            end
            ST_PIX_RD:
            begin
                cmd.pix_rd = warm;
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR:
            begin
                cmd.pix_wr = warm;
                it_next    = it_inc[19:0];
                wcnt_next  = '0;
                state_next = (it_inc == 21'(status.iters)) ? ST_FINISH : ST_WAVE;
            end
            ST_READ:
            begin
                cmd.idx_rd = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    case (func_reg)
                        adr_pkg::FUNC_RUN:  cmd.out_kind = adr_pkg::OUT_COUNT;
                        adr_pkg::FUNC_READ: cmd.out_kind = adr_pkg::OUT_PIXEL;
                        default:            cmd.out_kind = adr_pkg::OUT_ZERO;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            it_reg    <= '0;
            wcnt_reg  <= '0;
            func_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            it_reg    <= it_next;
            wcnt_reg  <= wcnt_next;
            func_reg  <= func_next;
        end
    end

endmodule

FILE: src/adr_datapath.sv
module adr_datapath #(
    parameter int TEX_SIDE         = adr_pkg::TEX_SIDE_DEF,
    parameter int SINE_TABLE_DEPTH = adr_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [20:0]          cfg_data,
    input  logic signed [17:0]   start_x,
    input  logic signed [17:0]   start_y,
    input  logic [15:0]          pixel_index,
    input  adr_pkg::adr_cmd_t    cmd,
    output adr_pkg::adr_status_t status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          red,
    output logic [15:0]          green,
    output logic [15:0]          blue,
    output logic [19:0]          saturated_count
);

    localparam int PIXELS  = TEX_SIDE * TEX_SIDE;
    localparam int ADDR_W  = $clog2(PIXELS);
    localparam int COORD_W = $clog2(TEX_SIDE);
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);

    function automatic logic [15:0] sat16(logic [20:0] s);
        return (s > 21'(adr_pkg::CH_MAX)) ? adr_pkg::CH_MAX : s[15:0];
    endfunction

    function automatic logic [15:0] fade16(logic [15:0] ch, logic [15:0] f);
        logic [31:0] p;
        p = 32'(ch) * 32'(f);
        return p[31:16];
    endfunction

    // Configuration registers.
    logic signed [20:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic [15:0]        bright_reg;
    logic [19:0]        iters_reg;
    logic [15:0]        fade_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= '0;
            bright_reg <= 16'd1250;
            iters_reg  <= 20'd25000;
            fade_reg   <= 16'd62259;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                adr_pkg::REG_COEF_A:     coef_a_reg <= cfg_data;
                adr_pkg::REG_COEF_B:     coef_b_reg <= cfg_data;
                adr_pkg::REG_COEF_C:     coef_c_reg <= cfg_data;
                adr_pkg::REG_COEF_D:     coef_d_reg <= cfg_data;
                adr_pkg::REG_BRIGHTNESS: bright_reg <= cfg_data[15:0];
                adr_pkg::REG_ITERATIONS: iters_reg  <= cfg_data[19:0];
                adr_pkg::REG_FADE:       fade_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Trajectory point and the captured read index.
    logic signed [18:0] x_reg, y_reg, x2_reg, y2_reg;
    logic [15:0]        pidx_reg;

    // Wave pipeline: coef*v, times 1/(2*pi), phase, table index, table read.
    logic signed [20:0] coef_sel;
    logic signed [18:0] v_sel;
    logic signed [39:0] p1_reg;
    logic signed [50:0] mhi_reg;
    logic [49:0]        mlo_reg;
    logic [15:0]        phase_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic signed [17:0] rom_q;
    logic [1:0]         tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic               vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic signed [17:0] wv_reg [4];
    logic [63:0]        turn_sum;
    logic [15:0]        phase_next;
    logic [31:0]        idx_prod;

    always_comb
    begin
        case (cmd.wave_slot)
            2'd0:    begin coef_sel = coef_a_reg; v_sel = y_reg; end
            2'd1:    begin coef_sel = coef_b_reg; v_sel = x_reg; end
            2'd2:    begin coef_sel = coef_c_reg; v_sel = x_reg; end
            default: begin coef_sel = coef_d_reg; v_sel = y_reg; end
        endcase
    end

    assign turn_sum   = {mhi_reg[43:0], 20'b0} + {14'b0, mlo_reg};
    // Cosine slots are odd and get a quarter turn added.
    assign phase_next = turn_sum[63:48] + (tag2_reg[0] ? 16'd16384 : 16'd0);
    assign idx_prod   = 32'(phase_reg) * 32'(SINE_TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        p1_reg    <= 40'(coef_sel) * 40'(v_sel);
        mhi_reg   <= 51'($signed(p1_reg[39:20])) * 51'(adr_pkg::INV_TWO_PI_Q32);
        mlo_reg   <= 50'(p1_reg[19:0]) * 50'(adr_pkg::INV_TWO_PI_Q32);
        phase_reg <= phase_next;
        idx_reg   <= idx_prod[16 +: IDX_W];
        tag1_reg  <= cmd.wave_slot;
        tag2_reg  <= tag1_reg;
        tag3_reg  <= tag2_reg;
        tag4_reg  <= tag3_reg;
        tag5_reg  <= tag4_reg;
        if (vld5_reg) wv_reg[tag5_reg] <= rom_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= cmd.wave_issue;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    adr_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk     (clk),
        .addr    (idx_reg),
        .rd_data (rom_q)
    );

    // Coordinate mapping and red/green increments.
    logic signed [23:0] ux, uy;
    logic [32:0]        wxp, wyp;
    logic [adr_pkg::W_W-1:0] wx_reg, wy_reg;
    logic signed [19:0] dxs, dys;
    logic [19:0]        adx, ady;
    logic [35:0]        drp, dgp;
    logic [19:0]        dr_reg, dg_reg;
    logic [33:0]        qxp, qyp;
    logic [11:0]        qx, qy;
    logic [COORD_W-1:0] col_reg, row_reg;
    logic [ADDR_W-1:0]  addr_reg;

    assign ux  = 24'(x2_reg) * 24'sd12 + adr_pkg::COORD_OFFSET;
    assign uy  = 24'(y2_reg) * 24'sd12 + adr_pkg::COORD_OFFSET;
    assign wxp = (ux < 0) ? '0 : 33'(ux[22:0]) * 33'(TEX_SIDE);
    assign wyp = (uy < 0) ? '0 : 33'(uy[22:0]) * 33'(TEX_SIDE);
    assign dxs = 20'(x2_reg) - 20'(x_reg);
    assign dys = 20'(y2_reg) - 20'(y_reg);
    assign adx = (dxs < 0) ? 20'(-dxs) : 20'(dxs);
    assign ady = (dys < 0) ? 20'(-dys) : 20'(dys);
    assign drp = 36'(adx) * 36'(bright_reg);
    assign dgp = 36'(ady) * 36'(bright_reg);
    assign qxp = 34'(wx_reg) * 34'(adr_pkg::RECIP_50);
    assign qyp = 34'(wy_reg) * 34'(adr_pkg::RECIP_50);
    assign qx  = qxp[adr_pkg::RECIP_SHIFT +: 12];
    assign qy  = qyp[adr_pkg::RECIP_SHIFT +: 12];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= 19'(start_x);
            y_reg    <= 19'(start_y);
            pidx_reg <= pixel_index;
        end
        else if (cmd.coord_a)
        begin
            x_reg <= x2_reg;
            y_reg <= y2_reg;
        end
        if (cmd.newpt)
        begin
            x2_reg <= 19'(wv_reg[0]) - 19'(wv_reg[1]);
            y2_reg <= 19'(wv_reg[2]) - 19'(wv_reg[3]);
        end
        if (cmd.coord_a)
        begin
            wx_reg <= wxp[16 +: adr_pkg::W_W];
            wy_reg <= wyp[16 +: adr_pkg::W_W];
            dr_reg <= drp[35:16];
            dg_reg <= dgp[35:16];
        end
        if (cmd.coord_b)
        begin
            col_reg <= (qx > 12'(TEX_SIDE - 1)) ? COORD_W'(TEX_SIDE - 1) : qx[COORD_W-1:0];
            row_reg <= (qy > 12'(TEX_SIDE - 1)) ? COORD_W'(TEX_SIDE - 1) : qy[COORD_W-1:0];
        end
        if (cmd.addr_calc)
            addr_reg <= ADDR_W'(row_reg) * ADDR_W'(TEX_SIDE) + ADDR_W'(col_reg);
    end

    // Pixel store, {blue, green, red} per entry.
    logic [47:0]       store_mem [PIXELS];
    logic [47:0]       mem_q_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic [ADDR_W-1:0] fade_addr_reg;
    logic              fade_pend_reg;
    logic [ADDR_W-1:0] raddr;
    logic [31:0]       pidx_wide;
    logic              in_range_reg;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [47:0]       wdata;
    logic [15:0]       new_red, new_green, new_blue;
    logic [19:0]       cnt_reg;

    assign pidx_wide = 32'(pidx_reg);
    assign raddr = cmd.fade_rd ? sweep_reg :
                   cmd.pix_rd  ? addr_reg  : pidx_wide[ADDR_W-1:0];

    assign new_red   = sat16(21'(mem_q_reg[15:0]) + 21'(dr_reg));
    assign new_green = sat16(21'(mem_q_reg[31:16]) + 21'(dg_reg));
    assign new_blue  = sat16(21'(mem_q_reg[47:32]) + 21'(bright_reg));

    always_comb
    begin
        we    = 1'b0;
        waddr = sweep_reg;
        wdata = '0;
        if (cmd.clr_wr)
        begin
            we = 1'b1;
        end
        else if (fade_pend_reg)
        begin
            we    = 1'b1;
            waddr = fade_addr_reg;
            wdata = {fade16(mem_q_reg[47:32], fade_reg),
                     fade16(mem_q_reg[31:16], fade_reg),
                     fade16(mem_q_reg[15:0], fade_reg)};
        end
        else if (cmd.pix_wr)
        begin
            we    = 1'b1;
            waddr = addr_reg;
            wdata = {new_blue, new_green, new_red};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we) store_mem[waddr] <= wdata;
        if (cmd.fade_rd || cmd.pix_rd || cmd.idx_rd) mem_q_reg <= store_mem[raddr];
        if (cmd.idx_rd) in_range_reg <= (pidx_wide < 32'(PIXELS));
        fade_addr_reg <= sweep_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            fade_pend_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cmd.sweep_clr)
                sweep_reg <= '0;
            else if (cmd.sweep_inc)
                sweep_reg <= sweep_reg + ADDR_W'(1);
            fade_pend_reg <= cmd.fade_rd;
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.pix_wr && new_blue == adr_pkg::CH_MAX)
                cnt_reg <= cnt_reg + 20'd1;
        end
    end

    // Output register; it frees up in the cycle its transaction completes.
    logic        out_valid_reg;
    logic [15:0] out_red_reg, out_green_reg, out_blue_reg;
    logic [19:0] out_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_red_reg   <= '0;
            out_green_reg <= '0;
            out_blue_reg  <= '0;
            out_cnt_reg   <= '0;
            case (cmd.out_kind)
                adr_pkg::OUT_PIXEL:
                begin
                    if (in_range_reg)
                    begin
                        out_red_reg   <= mem_q_reg[15:0];
                        out_green_reg <= mem_q_reg[31:16];
                        out_blue_reg  <= mem_q_reg[47:32];
                    end
                end
                adr_pkg::OUT_COUNT: out_cnt_reg <= cnt_reg;
                default: ;
            endcase
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign red             = out_red_reg;
    assign green           = out_green_reg;
    assign blue            = out_blue_reg;
    assign saturated_count = out_cnt_reg;

    assign status.sweep_last = (sweep_reg == ADDR_W'(PIXELS - 1));
    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.iters      = iters_reg;

endmodule

FILE: src/attractor_density_renderer_core.sv
// Density renderer for the de Jong map x' = sin(a*y) - cos(b*x),
// y' = sin(c*x) - cos(d*y) in Q16, drawn into an on-chip RGB store of
// TEX_SIDE*TEX_SIDE pixels whose 16-bit channels saturate. Each input
// transaction carries an operation in s_tuser: fade scales every channel by
// the fade register, run iterates the map from the given start point and
// accumulates hits after the warm-up steps, read returns one pixel. Every
// input transaction yields exactly one output transaction; only read fills
// the color fields and only run fills the saturation count. After reset the
// block clears the store, one pixel per cycle, and takes no input
// transaction until that is done; configuration writes are taken at any
// time. A run steps the map through one shared sine pipeline that
// evaluates the four waves of a step back to back, followed by the
// coordinate mapping and the read-modify-write of the hit pixel. A fade
// goes one pixel per cycle through the store's read and write ports. The
// output is registered, so a new item is taken while a finished result
// waits on m_tready.
module attractor_density_renderer_core #(
    parameter int TEX_SIDE         = adr_pkg::TEX_SIDE_DEF,
    parameter int WARMUP_STEPS     = adr_pkg::WARMUP_STEPS_DEF,
    parameter int SINE_TABLE_DEPTH = adr_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0: start_x[17:0], start_y[17:0], pixel_index[15:0], zero pad.
    input  logic [55:0] s_tdata,
    // func[1:0]: 0 fade, 1 run, 2 read.
    input  logic [1:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: red[15:0], green[15:0], blue[15:0], saturated_count[19:0], zero pad.
    output logic [71:0] m_tdata,
    // Configuration writes; the register index follows the register list.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [20:0] cfg_data
);

    adr_pkg::adr_cmd_t    cmd;
    adr_pkg::adr_status_t status;
    logic [15:0]          red, green, blue;
    logic [19:0]          saturated_count;

    // Registers are plain flops, so a configuration transaction never stalls.
    assign cfg_ready = 1'b1;

    adr_ctrl #(
        .WARMUP_STEPS (WARMUP_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    adr_datapath #(
        .TEX_SIDE         (TEX_SIDE),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .start_x         (s_tdata[17:0]),
        .start_y         (s_tdata[35:18]),
        .pixel_index     (s_tdata[51:36]),
        .cmd             (cmd),
        .status          (status),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .saturated_count (saturated_count)
    );

    assign m_tdata = {4'b0, saturated_count, blue, green, red};

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE   = adr_pkg::TEX_SIDE_DEF;
    localparam int WARMUP = adr_pkg::WARMUP_STEPS_DEF;
    localparam int DEPTH  = adr_pkg::SINE_TABLE_DEPTH_DEF;
    localparam int PIXELS = SIDE * SIDE;

    typedef struct packed {
        logic [19:0] sat_count;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } pixel_result_t;

    // Tracks the image store and the register file and predicts the one result
    // that every accepted input transaction produces.
    class density_scoreboard;
        logic [15:0]   red_px[PIXELS];
        logic [15:0]   grn_px[PIXELS];
        logic [15:0]   blu_px[PIXELS];
        int            sine_lut[DEPTH];
        longint        coef[4];
        int unsigned   bright;
        int unsigned   steps;
        int unsigned   fade_mul;
        pixel_result_t pending_results[$];
        int            lit_pixels[$];
        int            mismatches;
        int            n_fade, n_run, n_read, n_none, n_sat_hits, n_nonzero_reads;

        function new();
            longint th, term, sum, q;
            logic   neg;
            for (int i = 0; i < DEPTH; i++)
            begin
                th  = (longint'(i) * adr_pkg::TWO_PI_Q30) / DEPTH;
                neg = 1'b0;
                if (th >= adr_pkg::PI_Q30)
                begin
                    th  = th - adr_pkg::PI_Q30;
                    neg = 1'b1;
                end
                if (th > adr_pkg::HALF_PI_Q30) th = adr_pkg::PI_Q30 - th;
                term = th;
                sum  = th;
                // Taylor series through x^13, every term truncated.
                for (int k = 1; k <= 6; k++)
                begin
                    term = (term * th) >>> 30;
                    term = (term * th) >>> 30;
                    term = term / ((2 * k) * (2 * k + 1));
                    sum  = (k % 2 == 1) ? sum - term : sum + term;
                end
                if (sum < 0) sum = 0;
                q = (sum + 8192) >>> 14;
                if (q > 65536) q = 65536;
                sine_lut[i] = neg ? -int'(q) : int'(q);
            end
            foreach (red_px[i])
            begin
                red_px[i] = '0;
                grn_px[i] = '0;
                blu_px[i] = '0;
            end
            coef     = '{0, 0, 0, 0};
            bright   = 1250;
            steps    = 25000;
            fade_mul = 62259;
        endfunction

        function void set_reg(adr_pkg::reg_idx_t idx, logic [20:0] value);
            case (idx)
                adr_pkg::REG_COEF_A, adr_pkg::REG_COEF_B,
                adr_pkg::REG_COEF_C, adr_pkg::REG_COEF_D:
                    coef[idx] = longint'($signed(value));
                adr_pkg::REG_BRIGHTNESS: bright   = value[15:0];
                adr_pkg::REG_ITERATIONS: steps    = value[19:0];
                adr_pkg::REG_FADE:       fade_mul = value[15:0];
                default: ;
            endcase
        endfunction

        function int wave(longint c, longint v, bit cosine);
            longint      prod;
            logic [63:0] turn;
            logic [15:0] phase;
            int unsigned idx;
            prod  = c * v;
            turn  = prod * 64'd683565276;
            phase = turn[63:48] + (cosine ? 16'd16384 : 16'd0);
            idx   = (32'(phase) * DEPTH) >> 16;
            return sine_lut[idx];
        endfunction

        function int to_coord(longint v);
            longint n;
            longint c;
            n = 12 * v * SIDE + 25 * 65536 * longint'(SIDE);
            if (n < 0) return 0;
            c = n / (50 * 65536);
            return (c > SIDE - 1) ? SIDE - 1 : int'(c);
        endfunction

        function logic [15:0] sat16(logic [15:0] ch, longint unsigned inc);
            longint unsigned s;
            s = ch + inc;
            return (s > 65535) ? 16'hFFFF : s[15:0];
        endfunction

        function void note_item(adr_pkg::func_t f, logic [17:0] sx, logic [17:0] sy,
                                logic [15:0] pidx);
            pixel_result_t   res;
            longint          x, y, x2, y2, dx, dy;
            longint unsigned adx, ady;
            int              addr;
            res = '0;
            case (f)
                adr_pkg::FUNC_FADE:
                begin
                    n_fade++;
                    for (int i = 0; i < PIXELS; i++)
                    begin
                        red_px[i] = 16'((32'(red_px[i]) * fade_mul) >> 16);
                        grn_px[i] = 16'((32'(grn_px[i]) * fade_mul) >> 16);
                        blu_px[i] = 16'((32'(blu_px[i]) * fade_mul) >> 16);
                    end
                end
                adr_pkg::FUNC_RUN:
                begin
                    n_run++;
                    x = longint'($signed(sx));
                    y = longint'($signed(sy));
                    for (int unsigned i = 0; i < steps; i++)
                    begin
                        x2 = wave(coef[0], y, 0) - wave(coef[1], x, 1);
                        y2 = wave(coef[2], x, 0) - wave(coef[3], y, 1);
                        if (i >= WARMUP)
                        begin
                            dx   = x2 - x;
                            dy   = y2 - y;
                            adx  = (dx < 0) ? -dx : dx;
                            ady  = (dy < 0) ? -dy : dy;
                            addr = to_coord(y2) * SIDE + to_coord(x2);
                            red_px[addr] = sat16(red_px[addr], (bright * adx) >> 16);
                            grn_px[addr] = sat16(grn_px[addr], (bright * ady) >> 16);
                            blu_px[addr] = sat16(blu_px[addr], bright);
                            if (blu_px[addr] == 16'hFFFF) res.sat_count++;
                            if (lit_pixels.size() < 512) lit_pixels.push_back(addr);
                        end
                        x = x2;
                        y = y2;
                    end
                    n_sat_hits += res.sat_count;
                end
                adr_pkg::FUNC_READ:
                begin
                    n_read++;
                    if (pidx < PIXELS)
                    begin
                        res.red   = red_px[pidx];
                        res.green = grn_px[pidx];
                        res.blue  = blu_px[pidx];
                    end
                    if (res != '0) n_nonzero_reads++;
                end
                default: n_none++;
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [71:0] data);
            pixel_result_t got, want;
            got = data[67:0];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result transaction %h", data);
                return;
            end
            want = pending_results.pop_front();
            if (got != want || data[71:68] != '0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result r/g/b/count expected %0d/%0d/%0d/%0d,",
                             want.red, want.green, want.blue, want.sat_count,
                             " got %0d/%0d/%0d/%0d",
                             got.red, got.green, got.blue, got.sat_count);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [20:0] cfg_data = '0;

    density_scoreboard sb = new();
    bit no_idle = 1'b0;
    int hold_cycles = 0;

    always #1 clk = ~clk;

    attractor_density_renderer_core dut (.*);

    // Every accepted result transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (!no_idle && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic write_reg(adr_pkg::reg_idx_t idx, logic [20:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(adr_pkg::func_t f, logic [17:0] sx, logic [17:0] sy,
                             logic [15:0] pidx);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {4'b0, pidx, sy, sx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(f, sx, sy, pidx);
    endtask

    // Stops offering and waits until the block has delivered everything.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic read_pixel(int addr);
        send_item(adr_pkg::FUNC_READ, 18'($urandom), 18'($urandom), 16'(addr));
    endtask

    task automatic read_lit();
        if (sb.lit_pixels.size() > 0)
            read_pixel(sb.lit_pixels[$urandom_range(0, sb.lit_pixels.size() - 1)]);
        else
            read_pixel($urandom_range(0, PIXELS - 1));
    endtask

    task automatic run_from(logic [17:0] sx, logic [17:0] sy);
        send_item(adr_pkg::FUNC_RUN, sx, sy, 16'($urandom));
    endtask

    function automatic logic [20:0] rand_coef();
        return 21'($urandom_range(0, 1310720) - 655360);
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: empty store, unused operation gives an all-zero result.
        read_pixel(0);
        send_item(adr_pkg::FUNC_NONE, 18'h3FFFF, 18'h3FFFF, 16'hFFFF);
        drain();

        // A classic parameter set with a long run; the fade factor keeps its
        // reset value for the first fade.
        write_reg(adr_pkg::REG_COEF_A, 21'(91750));
        write_reg(adr_pkg::REG_COEF_B, 21'(-150733));
        write_reg(adr_pkg::REG_COEF_C, 21'(157286));
        write_reg(adr_pkg::REG_COEF_D, 21'(-137626));
        write_reg(adr_pkg::REG_BRIGHTNESS, 21'd40000);
        write_reg(adr_pkg::REG_ITERATIONS, 21'd4000);
        run_from(18'd0, 18'd0);
        repeat (4) read_lit();
        send_item(adr_pkg::FUNC_FADE, 18'd0, 18'd0, 16'd0);
        repeat (3) read_lit();
        drain();

        // Zero steps, then the smallest run that records a hit, with the
        // extreme start points and coefficients.
        write_reg(adr_pkg::REG_ITERATIONS, 21'd0);
        run_from(18'h20000, 18'h1FFFF);
        drain();
        write_reg(adr_pkg::REG_ITERATIONS, 21'(WARMUP + 1));
        write_reg(adr_pkg::REG_BRIGHTNESS, 21'd65535);
        write_reg(adr_pkg::REG_COEF_A, 21'(655360));
        write_reg(adr_pkg::REG_COEF_B, 21'(-655360));
        write_reg(adr_pkg::REG_COEF_C, 21'(-655360));
        write_reg(adr_pkg::REG_COEF_D, 21'(655360));
        run_from(18'h20000, 18'h1FFFF);
        run_from(18'h1FFFF, 18'h20000);
        run_from(18'(65536), 18'(-65536));
        repeat (2) read_lit();
        drain();
        write_reg(adr_pkg::REG_FADE, 21'd65535);
        send_item(adr_pkg::FUNC_FADE, 18'd0, 18'd0, 16'd0);
        read_lit();
        read_pixel(PIXELS - 1);
        drain();
        write_reg(adr_pkg::REG_FADE, 21'd0);
        write_reg(adr_pkg::REG_BRIGHTNESS, 21'd0);
        send_item(adr_pkg::FUNC_FADE, 18'd0, 18'd0, 16'd0);
        read_lit();
        run_from(18'd100, 18'd200);
        read_lit();
        drain();

        // Random phases: new registers each time, runs mixed with reads that
        // mostly land on pixels a run has hit.
        for (int ph = 0; ph < 5; ph++)
        begin
            no_idle = (ph == 4);
            for (int r = adr_pkg::REG_COEF_A; r <= adr_pkg::REG_COEF_D; r++)
                write_reg(adr_pkg::reg_idx_t'(r), rand_coef());
            write_reg(adr_pkg::REG_BRIGHTNESS,
                      ($urandom_range(0, 2) == 0) ? 21'($urandom_range(30000, 65535))
                                                  : 21'($urandom_range(0, 65535)));
            write_reg(adr_pkg::REG_ITERATIONS, 21'($urandom_range(WARMUP, 60)));
            write_reg(adr_pkg::REG_FADE, 21'($urandom_range(0, 65535)));
            if (ph == 2)
            begin
                // Long hold-off on the result side while reads keep coming,
                // so that the block fills up and stalls its input.
                hold_cycles = 300;
                repeat (6) read_lit();
            end
            for (int n = 0; n < 14; n++)
            begin
                case ($urandom_range(0, 19))
                    0: send_item(adr_pkg::FUNC_NONE, 18'($urandom), 18'($urandom),
                                 16'($urandom));
                    1, 2, 3, 4, 5, 6, 7:
                        run_from(18'($urandom_range(0, 131072) - 65536),
                                 18'($urandom_range(0, 131072) - 65536));
                    8, 9: run_from(18'($urandom), 18'($urandom));
                    10: read_pixel($urandom_range(0, PIXELS - 1));
                    default: read_lit();
                endcase
            end
            if (ph == 3)
                send_item(adr_pkg::FUNC_FADE, 18'($urandom), 18'($urandom), 16'($urandom));
            read_lit();
            drain();
        end

        $display("Covered %0d runs, %0d reads (%0d nonzero), %0d fades, %0d unused operations.",
                 sb.n_run, sb.n_read, sb.n_nonzero_reads, sb.n_fade, sb.n_none);
        $display("Runs produced %0d saturated blue hits; %0d result mismatches.",
                 sb.n_sat_hits, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

endmodule
